// ===== rtl/xxtea_block_cipher_macros.svh =====
// ----------------------------------------------------------------------------
// XXTEA block cipher assertion macros
// Concurrent assertion wrappers shared by the cipher modules; define
// ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef XXTEA_BLOCK_CIPHER_MACROS_SVH
`define XXTEA_BLOCK_CIPHER_MACROS_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define XXT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define XXT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define XXT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define XXT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/xxt_pkg.sv =====
// ----------------------------------------------------------------------------
// XXTEA package
// Sizes, cipher constants, register codes and the block transaction type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xxt_pkg;

    localparam int MAX_WORDS  = 8;
    localparam int MIN_WORDS  = 2;
    localparam int IDX_W      = $clog2(MAX_WORDS);
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int WORD_W     = 32;
    localparam int KEY_W      = 128;
    localparam int BW_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int ROUNDS     = 6;
    localparam int ROUND_W    = $clog2(ROUNDS);

    localparam logic [WORD_W-1:0] XX_DELTA   = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] XX_SUM_DEC = WORD_W'(64'(XX_DELTA) * 64'(ROUNDS));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW,
        CFG_KEY_HIGH,
        CFG_DECRYPT,
        CFG_BLOCK_WORDS
    } t_cfg_idx;

    // one complete block, with key and mode sampled when it completed
    typedef struct packed {
        logic [MAX_WORDS-1:0][WORD_W-1:0] words;
        logic [CNT_W-1:0]                 n;
        logic [KEY_W-1:0]                 key;
        logic                             decrypt;
    } t_block;

    typedef struct packed {
        logic   push;
        t_block blk;
    } t_push;

endpackage

// ===== rtl/xxt_loader.sv =====
// ----------------------------------------------------------------------------
// XXTEA block loader
// Collects input words into the word store and hands each completed block,
// with the key and mode in force, to the block queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xxt_loader import xxt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_data_word,
    input  logic [BW_W-1:0]   i_block_words,
    input  logic [KEY_W-1:0]  i_key,
    input  logic              i_decrypt,
    input  logic              i_q_full,
    output logic              o_busy,
    output t_push             o_push
);

    logic [WORD_W-1:0] r_store [MAX_WORDS];
    logic [IDX_W-1:0]  r_load_cnt;

    logic [CNT_W-1:0]  bw;
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  cnt_inc;
    logic              complete;
    logic              accept;

    always_comb begin
        bw = CNT_W'(i_block_words);
        // saturate the block size into the legal range
        if (bw < CNT_W'(MIN_WORDS)) begin
            n_eff = CNT_W'(MIN_WORDS);
        end else if (bw > CNT_W'(MAX_WORDS)) begin
            n_eff = CNT_W'(MAX_WORDS);
        end else begin
            n_eff = bw;
        end
        cnt_inc  = CNT_W'(r_load_cnt) + CNT_W'(1);
        complete = (cnt_inc >= n_eff);
        // stall only a word that would close a block with nowhere to go
        o_busy   = i_q_full && complete;
        accept   = i_start && !o_busy;
    end

    always_comb begin
        for (int i = 0; i < MAX_WORDS; i++) begin
            o_push.blk.words[i] = r_store[i];
        end
        o_push.blk.words[r_load_cnt] = i_data_word;
        o_push.blk.n       = n_eff;
        o_push.blk.key     = i_key;
        o_push.blk.decrypt = i_decrypt;
        o_push.push        = accept && complete;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (accept) begin
            r_load_cnt <= complete ? '0 : IDX_W'(cnt_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store[r_load_cnt] <= i_data_word;
        end
    end

endmodule

// ===== rtl/xxt_queue.sv =====
// ----------------------------------------------------------------------------
// XXTEA block queue
// Two-entry queue of completed blocks between the loader and the round engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xxtea_block_cipher_macros.svh"

module xxt_queue import xxt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_block o_head
);

    // depth must stay a power of two for the pointer wrap
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    t_block             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push.push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push.push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.blk;
        end
    end

    `XXT_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push.push, !o_full, "push into full queue")
    `XXT_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `XXT_ASSERT_NXT(a_head_holds, i_clk, i_rst_n, o_valid && !i_pop, $stable(o_head), "head moved")

endmodule

// ===== rtl/xxt_engine.sv =====
// ----------------------------------------------------------------------------
// XXTEA round engine
// Reads a queued block into a rotating word window, runs six XXTEA rounds at
// one mixing step per clock and streams the words out in block order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xxtea_block_cipher_macros.svh"

module xxt_engine import xxt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_block            i_q_head,
    output logic              o_pop,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_result_word,
    output logic              o_last_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_MIX,
        S_EMIT
    } t_state;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORDS);

    t_state             r_state;
    logic [WORD_W-1:0]  r_work [MAX_WORDS];
    logic [WORD_W-1:0]  r_zy;
    logic [WORD_W-1:0]  r_sum;
    logic [IDX_W-1:0]   r_p;
    logic [IDX_W-1:0]   r_k;
    logic [ROUND_W-1:0] r_round;
    logic [CNT_W-1:0]   r_n;
    logic [KEY_W-1:0]   r_key;
    logic               r_decrypt;
    logic               r_valid;
    logic [WORD_W-1:0]  r_result;
    logic               r_last;

    logic [IDX_W-1:0]   base;
    logic [IDX_W-1:0]   n_last;
    logic [1:0]         key_idx;
    logic [WORD_W-1:0]  key_word;
    logic [WORD_W-1:0]  y_sel;
    logic [WORD_W-1:0]  z_sel;
    logic [WORD_W-1:0]  mix_val;
    logic [WORD_W-1:0]  step_word;
    logic [WORD_W-1:0]  load_word;
    logic [WORD_W-1:0]  rot_in;
    logic [WORD_W-1:0]  emit_word;
    logic               load_last;
    logic               round_end;
    logic [WORD_W-1:0]  n_rot [MAX_WORDS];
    logic [WORD_W-1:0]  n_shd [MAX_WORDS];

    function automatic logic [WORD_W-1:0] f_mix(
        input logic [WORD_W-1:0] y,
        input logic [WORD_W-1:0] z,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] k
    );
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (k ^ z);
        return a ^ b;
    endfunction

    // The block sits in the top n entries of the window. Encryption keeps it
    // reversed (word 0 on top), decryption in order (last word on top); both
    // then update the top entry and rotate it to the bottom of the window.
    always_comb begin
        base      = IDX_W'(MAX_CNT - r_n);
        n_last    = IDX_W'(r_n - CNT_W'(1));
        key_idx   = r_p[1:0] ^ r_sum[3:2];
        key_word  = r_key[key_idx * WORD_W +: WORD_W];
        y_sel     = r_decrypt ? r_zy : r_work[MAX_WORDS-2];
        z_sel     = r_decrypt ? r_work[MAX_WORDS-2] : r_zy;
        mix_val   = f_mix(y_sel, z_sel, r_sum, key_word);
        step_word = r_decrypt ? (r_work[MAX_WORDS-1] - mix_val)
                              : (r_work[MAX_WORDS-1] + mix_val);
        load_word = i_q_head.words[r_k];
        load_last = r_decrypt ? (r_k == '0) : (r_k == n_last);
        round_end = r_decrypt ? (r_p == '0) : (r_p == n_last);
        rot_in    = (r_state == S_LOAD) ? load_word : step_word;
        emit_word = r_decrypt ? r_work[base] : r_work[MAX_WORDS-1];
        o_pop     = (r_state == S_LOAD) && load_last;

        n_rot[0] = (base == '0) ? rot_in : r_work[0];
        for (int i = 1; i < MAX_WORDS; i++) begin
            if (IDX_W'(i) == base) begin
                n_rot[i] = rot_in;
            end else if (IDX_W'(i) > base) begin
                n_rot[i] = r_work[i-1];
            end else begin
                n_rot[i] = r_work[i];
            end
        end

        for (int i = 0; i < MAX_WORDS - 1; i++) begin
            n_shd[i] = r_work[i+1];
        end
        n_shd[MAX_WORDS-1] = r_work[MAX_WORDS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_EMIT);
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_n       <= i_q_head.n;
                        r_key     <= i_q_head.key;
                        r_decrypt <= i_q_head.decrypt;
                        r_k       <= i_q_head.decrypt ? IDX_W'(i_q_head.n - CNT_W'(1)) : '0;
                        r_state   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_work <= n_rot;
                    // the last word read in seeds the running neighbor
                    r_zy   <= load_word;
                    if (load_last) begin
                        r_sum   <= r_decrypt ? XX_SUM_DEC : XX_DELTA;
                        r_p     <= r_decrypt ? n_last : '0;
                        r_round <= '0;
                        r_state <= S_MIX;
                    end else begin
                        r_k <= r_decrypt ? (r_k - IDX_W'(1)) : (r_k + IDX_W'(1));
                    end
                end
                S_MIX: begin
                    r_work <= n_rot;
                    r_zy   <= step_word;
                    if (round_end) begin
                        r_p     <= r_decrypt ? n_last : '0;
                        r_sum   <= r_decrypt ? (r_sum - XX_DELTA) : (r_sum + XX_DELTA);
                        r_round <= r_round + ROUND_W'(1);
                        if (r_round == ROUND_W'(ROUNDS - 1)) begin
                            r_k     <= '0;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_p <= r_decrypt ? (r_p - IDX_W'(1)) : (r_p + IDX_W'(1));
                    end
                end
                S_EMIT: begin
                    r_result <= emit_word;
                    r_last   <= (r_k == n_last);
                    if (r_decrypt) begin
                        r_work <= n_shd;
                    end else begin
                        r_work <= n_rot;
                    end
                    r_k      <= r_k + IDX_W'(1);
                    if (r_k == n_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_result_word = r_result;
    assign o_last_word   = r_last;

    `XXT_ASSERT_NXT(a_last_ends_burst, i_clk, i_rst_n, o_valid && o_last_word, !o_valid, "result after last word")
    `XXT_ASSERT_NXT(a_burst_gapless, i_clk, i_rst_n, o_valid && !o_last_word, o_valid, "gap inside result burst")
    `XXT_ASSERT_IMP(a_pop_has_block, i_clk, i_rst_n, o_pop, i_q_valid, "pop without queued block")

endmodule

// ===== rtl/xxtea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// XXTEA block cipher
// Encrypts or decrypts blocks of 2 to 8 32-bit words with six XXTEA rounds.
// Words enter one per transaction (start high while busy is low), first word
// first; a word is refused only when it would complete a block while two
// finished blocks already wait in the queue. Each block is read into the
// round engine word by word, mixed at one mixing step per clock through the
// single round adder path and streamed out in consecutive cycles on o_valid,
// o_last_word marking the final word. Results cannot be held off: the
// receiver must take every strobed word. Key and mode are sampled when the
// last word of a block is taken; the user must see that registers are
// written only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xxtea_block_cipher import xxt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [WORD_W-1:0]     i_data_word,
    output logic                  o_valid,
    output logic [WORD_W-1:0]     o_result_word,
    output logic                  o_last_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_key_low;
    logic [CFG_DATA_W-1:0] r_key_high;
    logic                  r_decrypt;
    logic [BW_W-1:0]       r_block_words;

    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_push  push;
    t_block q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low     <= '0;
            r_key_high    <= '0;
            r_decrypt     <= 1'b0;
            r_block_words <= BW_W'(4);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_LOW:     r_key_low     <= i_cfg_data;
                CFG_KEY_HIGH:    r_key_high    <= i_cfg_data;
                CFG_DECRYPT:     r_decrypt     <= i_cfg_data[0];
                CFG_BLOCK_WORDS: r_block_words <= i_cfg_data[BW_W-1:0];
                default:         r_decrypt     <= r_decrypt;
            endcase
        end
    end

    xxt_loader u_loader (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_data_word   (i_data_word),
        .i_block_words (r_block_words),
        .i_key         ({r_key_high, r_key_low}),
        .i_decrypt     (r_decrypt),
        .i_q_full      (q_full),
        .o_busy        (busy),
        .o_push        (push)
    );

    xxt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    xxt_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_head      (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_result_word (o_result_word),
        .o_last_word   (o_last_word)
    );

endmodule
